>>> hdl/rgbdl_pkg.sv
`default_nettype none

package rgbdl_pkg;

	localparam int SPAN_BITS  = 8;
	localparam int CHAN_BITS  = 4;
	localparam int NCHAN      = 3;
	localparam int COLOR_BITS = NCHAN * CHAN_BITS;
	localparam int QUO_BITS   = CHAN_BITS + 2;
	localparam int NUM_BITS   = SPAN_BITS + QUO_BITS;
	localparam int LATENCY    = 2 + QUO_BITS + 1;

	typedef logic [SPAN_BITS-1:0] span_t;
	typedef logic [COLOR_BITS-1:0] color_t;
	typedef logic [NUM_BITS-1:0] num_t;
	typedef logic [QUO_BITS-1:0] quo_t;
	typedef logic [NCHAN-1:0][NUM_BITS-1:0] num_vec_t;
	typedef logic [NCHAN-1:0][QUO_BITS-1:0] quo_vec_t;

	typedef struct packed {
		logic        zero;
		color_t      color_start;
		logic [1:0]  thr;
		span_t       n;
	} side_t;

	function automatic logic [1:0] dither_thr(input logic [1:0] sel);
		logic [1:0] thr;
		case (sel)
			2'd0: thr = 2'd0;
			2'd1: thr = 2'd2;
			2'd2: thr = 2'd1;
			2'd3: thr = 2'd3;
			default: thr = 2'd0;
		endcase
		return thr;
	endfunction

endpackage

`default_nettype wire

>>> hdl/rgbdl_front.sv
`default_nettype none

module rgbdl_front (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	input  wire rgbdl_pkg::color_t   color_start,
	input  wire rgbdl_pkg::color_t   color_end,
	input  wire rgbdl_pkg::span_t    position,
	input  wire rgbdl_pkg::span_t    span_length,
	input  wire logic [7:0]          line_number,
	output logic                     valid_s2,
	output rgbdl_pkg::num_vec_t      num_s2,
	output rgbdl_pkg::side_t         side_s2
);
	import rgbdl_pkg::*;

	localparam int SUM_BITS = NUM_BITS - 2;

	logic   valid_s1;
	span_t  t_s1;
	span_t  nt_s1;
	color_t color_end_s1;
	side_t  side_s1;
	span_t  t_clamp;
	logic [NCHAN-1:0][SUM_BITS-1:0] sum;

	assign t_clamp = (position > span_length) ? span_length : position;

	always_comb begin
		for (int c = 0; c < NCHAN; c++) begin
			sum[c] = SUM_BITS'(side_s1.color_start[c*CHAN_BITS +: CHAN_BITS]) * SUM_BITS'(nt_s1)
				+ SUM_BITS'(color_end_s1[c*CHAN_BITS +: CHAN_BITS]) * SUM_BITS'(t_s1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		t_s1                <= t_clamp;
		nt_s1               <= span_length - t_clamp;
		color_end_s1        <= color_end;
		side_s1.zero        <= (span_length == '0);
		side_s1.color_start <= color_start;
		side_s1.thr         <= dither_thr(line_number[1:0]);
		side_s1.n           <= span_length;
		for (int c = 0; c < NCHAN; c++) begin
			num_s2[c] <= {sum[c], 2'b00};
		end
		side_s2 <= side_s1;
	end

endmodule

`default_nettype wire

>>> hdl/rgbdl_divider.sv
`default_nettype none

module rgbdl_divider (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 valid_in,
	input  wire rgbdl_pkg::num_vec_t  num_in,
	input  wire rgbdl_pkg::side_t     side_in,
	output logic                      valid_out,
	output rgbdl_pkg::quo_vec_t       quo_out,
	output rgbdl_pkg::side_t          side_out
);
	import rgbdl_pkg::*;

	// One quotient bit per stage, most significant first, for all channels at once.
	logic     vld_s  [QUO_BITS];
	num_vec_t rem_s  [QUO_BITS];
	quo_vec_t quo_s  [QUO_BITS];
	side_t    side_s [QUO_BITS];

	for (genvar k = 0; k < QUO_BITS; k++) begin : g_stage
		localparam int SH = QUO_BITS - 1 - k;

		logic     vld_src;
		num_vec_t rem_src;
		quo_vec_t quo_src;
		side_t    side_src;
		num_t     dvs;
		num_vec_t rem_nx;
		quo_vec_t quo_nx;

		if (k == 0) begin : g_first
			assign vld_src  = valid_in;
			assign rem_src  = num_in;
			assign quo_src  = '0;
			assign side_src = side_in;
		end else begin : g_next
			assign vld_src  = vld_s[k-1];
			assign rem_src  = rem_s[k-1];
			assign quo_src  = quo_s[k-1];
			assign side_src = side_s[k-1];
		end

		assign dvs = NUM_BITS'(side_src.n) << SH;

		always_comb begin
			for (int c = 0; c < NCHAN; c++) begin
				rem_nx[c] = rem_src[c];
				quo_nx[c] = quo_src[c];
				if (rem_src[c] >= dvs) begin
					rem_nx[c]     = rem_src[c] - dvs;
					quo_nx[c][SH] = 1'b1;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else begin
				vld_s[k] <= vld_src;
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k]  <= rem_nx;
			quo_s[k]  <= quo_nx;
			side_s[k] <= side_src;
		end
	end

	assign valid_out = vld_s[QUO_BITS-1];
	assign quo_out   = quo_s[QUO_BITS-1];
	assign side_out  = side_s[QUO_BITS-1];

endmodule

`default_nettype wire

>>> hdl/rgbdl_dither.sv
`default_nettype none

module rgbdl_dither (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 valid_in,
	input  wire rgbdl_pkg::quo_vec_t  quo_in,
	input  wire rgbdl_pkg::side_t     side_in,
	output logic                      done,
	output rgbdl_pkg::color_t         color_out
);
	import rgbdl_pkg::*;

	color_t packed_color;

	always_comb begin
		for (int c = 0; c < NCHAN; c++) begin
			packed_color[c*CHAN_BITS +: CHAN_BITS] = quo_in[c][QUO_BITS-1:2]
				+ CHAN_BITS'(quo_in[c][1:0] > side_in.thr);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		color_out <= side_in.zero ? side_in.color_start : packed_color;
	end

endmodule

`default_nettype wire

>>> hdl/rgb444_gradient_dither_lerp_unit.sv
// color_out and done are registered in the output stage, which follows the front and divider stages.
// Throughput: one item per cycle; busy stays low, so start may be held high continuously.
// The pipeline is two front stages, the six-stage restoring divider and one output stage.
// The receiver cannot stall; each result is shown for exactly one cycle with done.
// Reset (arst_n low) clears all valid bits at once; items in flight are dropped.
`default_nettype none

module rgb444_gradient_dither_lerp_unit (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	output logic                     busy,
	input  wire rgbdl_pkg::color_t   color_start,
	input  wire rgbdl_pkg::color_t   color_end,
	input  wire rgbdl_pkg::span_t    position,
	input  wire rgbdl_pkg::span_t    span_length,
	input  wire logic [7:0]          line_number,
	output logic                     done,
	output rgbdl_pkg::color_t        color_out
);
	import rgbdl_pkg::*;

	logic     valid_s2;
	num_vec_t num_s2;
	side_t    side_s2;
	logic     div_valid;
	quo_vec_t div_quo;
	side_t    div_side;

	assign busy = 1'b0;

	rgbdl_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (start && !busy),
		.color_start (color_start),
		.color_end   (color_end),
		.position    (position),
		.span_length (span_length),
		.line_number (line_number),
		.valid_s2    (valid_s2),
		.num_s2      (num_s2),
		.side_s2     (side_s2)
	);

	rgbdl_divider u_divider (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_in  (valid_s2),
		.num_in    (num_s2),
		.side_in   (side_s2),
		.valid_out (div_valid),
		.quo_out   (div_quo),
		.side_out  (div_side)
	);

	rgbdl_dither u_dither (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_in  (div_valid),
		.quo_in    (div_quo),
		.side_in   (div_side),
		.done      (done),
		.color_out (color_out)
	);

endmodule

`default_nettype wire

>>> hdl/rgbdl_checker.sv
`default_nettype none

module rgbdl_checker (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                start,
	input wire logic                busy,
	input wire rgbdl_pkg::color_t   color_start,
	input wire rgbdl_pkg::color_t   color_end,
	input wire rgbdl_pkg::span_t    position,
	input wire rgbdl_pkg::span_t    span_length,
	input wire logic                done,
	input wire rgbdl_pkg::color_t   color_out
);
	import rgbdl_pkg::*;

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy was raised although the pipeline never stalls.");

	a_item_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LATENCY done)
		else $error("An accepted item did not produce a result on time.");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("A result appeared without a matching item.");

	a_zero_span: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && span_length == '0)
			|-> ##LATENCY (color_out == $past(color_start, LATENCY)))
		else $error("A zero span did not return the start color.");

	a_end_color: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && span_length != '0 && position >= span_length)
			|-> ##LATENCY (color_out == $past(color_end, LATENCY)))
		else $error("A position at or past the span did not return the end color.");

endmodule

bind rgb444_gradient_dither_lerp_unit rgbdl_checker u_rgbdl_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.color_start (color_start),
	.color_end   (color_end),
	.position    (position),
	.span_length (span_length),
	.done        (done),
	.color_out   (color_out)
);

`default_nettype wire
